// File: sv/wprlm_pkg.sv
// ----------------------------------------------------------------------------
// wprlm_pkg
// shared types and constants of the windowed peak and rms level meter
// ----------------------------------------------------------------------------
package wprlm_pkg;

  localparam int unsigned FieldW    = 16;
  localparam int unsigned SumW      = 48;
  localparam int unsigned RootW     = SumW / 2;
  localparam int unsigned RemW      = RootW + 2;
  localparam int unsigned DivSteps  = SumW;
  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned CntW      = $clog2(DivSteps);
  localparam logic [FieldW-1:0] WindowReset = FieldW'(480);

  typedef logic [FieldW-1:0] field_t;

  typedef struct packed {
    logic acc;
    logic close;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic window_full;
  } sts_t;

endpackage

// File: sv/wprlm_smp_if.sv
// ----------------------------------------------------------------------------
// wprlm_smp_if
// sample channel carrying one magnitude per beat
// ----------------------------------------------------------------------------
interface wprlm_smp_if;
  logic        valid;
  logic        ready;
  logic [15:0] magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink (input valid, input magnitude, output ready);
endinterface

// File: sv/wprlm_res_if.sv
// ----------------------------------------------------------------------------
// wprlm_res_if
// result channel carrying rms and peak levels per beat
// ----------------------------------------------------------------------------
interface wprlm_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] rms_level;
  logic [15:0] peak_level;

  modport source (output valid, output rms_level, output peak_level, input ready);
  modport sink (input valid, input rms_level, input peak_level, output ready);
endinterface

// File: sv/wprlm_cfg_if.sv
// ----------------------------------------------------------------------------
// wprlm_cfg_if
// configuration write channel for the window length
// ----------------------------------------------------------------------------
interface wprlm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink (input valid, input window_len, output ready);
endinterface

// File: sv/windowed_peak_rms_level_meter.sv
// ----------------------------------------------------------------------------
// windowed_peak_rms_level_meter
// Q1.15 magnitude stream in, one peak and rms result per measurement window
// out. While a window fills, a sample beat is taken every cycle. The beat
// after a full window closes it and is not counted; the block then stays
// busy through the one-bit-per-cycle restoring divider for sum /
// window_len, the two-bit-per-cycle integer square root, and the handoff
// into the result register with the return to idle, and longer only if an
// earlier result still waits downstream. A window length of zero closes
// on every beat with rms zero. rms saturates at 0xffff.
// ----------------------------------------------------------------------------
module windowed_peak_rms_level_meter (
  input logic  clk_i,
  input logic  rst_ni,
  wprlm_smp_if.sink   smp,
  wprlm_res_if.source res,
  wprlm_cfg_if.sink   cfg
);
  import wprlm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  wprlm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .smp_valid_i (smp.valid),
    .smp_ready_o (smp.ready),
    .res_valid_o (res.valid),
    .res_ready_i (res.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wprlm_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .magnitude_i  (smp.magnitude),
    .cfg_we_i     (cfg.valid && cfg.ready),
    .window_len_i (cfg.window_len),
    .rms_level_o  (res.rms_level),
    .peak_level_o (res.peak_level)
  );

`ifndef ASSERT_OFF
  a_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.close |=> !smp.ready)
    else $error("sample beat taken while a window result is computed");

  a_acc_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.acc |-> (smp.valid && smp.ready && !sts.window_full))
    else $error("accumulate without an open window beat");

  a_res_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res.valid) |-> $past(cmd.load_out))
    else $error("result valid without a result load");
`endif

endmodule

// File: sv/wprlm_datapath.sv
// ----------------------------------------------------------------------------
// wprlm_datapath
// accumulators, shared bit-serial divider and square root, result register
// ----------------------------------------------------------------------------
module wprlm_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wprlm_pkg::cmd_t   cmd_i,
  output wprlm_pkg::sts_t   sts_o,
  input  wprlm_pkg::field_t magnitude_i,
  input  logic              cfg_we_i,
  input  wprlm_pkg::field_t window_len_i,
  output wprlm_pkg::field_t rms_level_o,
  output wprlm_pkg::field_t peak_level_o
);
  import wprlm_pkg::*;

  field_t              win_q, win_d;
  field_t              count_q, count_d;
  field_t              peak_q, peak_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic [2*FieldW-1:0] sq_q, sq_d;
  logic                sq_vld_q, sq_vld_d;
  logic [SumW-1:0]     sh_q, sh_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [RootW-1:0]    root_q, root_d;
  field_t              pk_hold_q, pk_hold_d;
  logic                wz_q, wz_d;
  field_t              rms_q, rms_d;
  field_t              pk_out_q, pk_out_d;

  logic [SumW-1:0]     sum_nxt;
  logic [FieldW:0]     div_sh;
  logic                div_ge;
  logic [RemW-1:0]     sq_sh;
  logic [RemW-1:0]     sq_trial;
  logic                sq_ge;

  assign sum_nxt  = sum_q + (sq_vld_q ? {{(SumW-2*FieldW){1'b0}}, sq_q} : '0);
  assign div_sh   = {rem_q[FieldW-1:0], sh_q[SumW-1]};
  assign div_ge   = div_sh >= {1'b0, win_q};
  assign sq_sh    = {rem_q[RemW-3:0], sh_q[SumW-1:SumW-2]};
  assign sq_trial = {root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  assign sts_o.window_full = !(count_q < win_q);

  always_comb begin
    win_d     = win_q;
    count_d   = count_q;
    peak_d    = peak_q;
    sum_d     = sum_nxt;
    sq_d      = sq_q;
    sq_vld_d  = 1'b0;
    sh_d      = sh_q;
    rem_d     = rem_q;
    root_d    = root_q;
    pk_hold_d = pk_hold_q;
    wz_d      = wz_q;
    rms_d     = rms_q;
    pk_out_d  = pk_out_q;

    if (cfg_we_i) begin
      win_d = window_len_i;
    end

    if (cmd_i.acc) begin
      count_d  = count_q + FieldW'(1);
      sq_d     = (2*FieldW)'(magnitude_i) * (2*FieldW)'(magnitude_i);
      sq_vld_d = 1'b1;
      if (magnitude_i > peak_q) begin
        peak_d = magnitude_i;
      end
    end

    if (cmd_i.close) begin
      sh_d      = sum_nxt;
      sum_d     = '0;
      count_d   = '0;
      peak_d    = '0;
      pk_hold_d = peak_q;
      wz_d      = (win_q == '0);
      rem_d     = '0;
    end

    if (cmd_i.div_step) begin
      sh_d  = {sh_q[SumW-2:0], div_ge};
      rem_d = div_ge ? RemW'(div_sh - {1'b0, win_q}) : RemW'(div_sh);
    end

    if (cmd_i.sqrt_start) begin
      rem_d  = '0;
      root_d = '0;
    end

    if (cmd_i.sqrt_step) begin
      sh_d   = {sh_q[SumW-3:0], 2'b00};
      rem_d  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
      root_d = {root_q[RootW-2:0], sq_ge};
    end

    if (cmd_i.load_out) begin
      pk_out_d = pk_hold_q;
      if (wz_q) begin
        rms_d = '0;
      end else if (|root_q[RootW-1:FieldW]) begin
        rms_d = '1;
      end else begin
        rms_d = root_q[FieldW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= WindowReset;
      count_q  <= '0;
      peak_q   <= '0;
      sum_q    <= '0;
      sq_vld_q <= 1'b0;
    end else begin
      win_q    <= win_d;
      count_q  <= count_d;
      peak_q   <= peak_d;
      sum_q    <= sum_d;
      sq_vld_q <= sq_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q      <= sq_d;
    sh_q      <= sh_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    pk_hold_q <= pk_hold_d;
    wz_q      <= wz_d;
    rms_q     <= rms_d;
    pk_out_q  <= pk_out_d;
  end

  assign rms_level_o  = rms_q;
  assign peak_level_o = pk_out_q;

endmodule

// File: sv/wprlm_ctrl.sv
// ----------------------------------------------------------------------------
// wprlm_ctrl
// sequencer for accumulate, divide, square root and result handoff
// ----------------------------------------------------------------------------
module wprlm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            smp_valid_i,
  output logic            smp_ready_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  input  wprlm_pkg::sts_t sts_i,
  output wprlm_pkg::cmd_t cmd_o
);
  import wprlm_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSqrt = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_vld_q, out_vld_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    smp_ready_o = 1'b0;

    unique case (state_q)
      StIdle: begin
        smp_ready_o = 1'b1;
        if (smp_valid_i) begin
          if (!sts_i.window_full) begin
            cmd_o.acc = 1'b1;
          end else begin
            cmd_o.close = 1'b1;
            cnt_d       = '0;
            state_d     = StDiv;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DivSteps - 1)) begin
          cmd_o.sqrt_start = 1'b1;
          cnt_d            = '0;
          state_d          = StSqrt;
        end
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + CntW'(1);
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!out_vld_q || res_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    out_vld_d = out_vld_q && !res_ready_i;
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign res_valid_o = out_vld_q;

endmodule
